/* rtl/hbc_pkg.sv */
// Shared constants, codes and types of the histogram binning counter.
`default_nettype none
package hbc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COUNT_BITS  = 24;
    localparam int MAX_BINS    = 256;
    localparam int BIN_BITS    = $clog2(MAX_BINS);
    localparam int NB_BITS     = BIN_BITS + 1;
    localparam int MIN_BINS    = 3;

    // Quotient bits resolved by the divide chain; covers every bin count
    // with one bit to spare, anything larger flags overflow at the head.
    localparam int QUO_BITS = NB_BITS + 1;
    localparam int REM_BITS = SAMPLE_BITS + NB_BITS;
    localparam int DEN_BITS = SAMPLE_BITS + QUO_BITS - 1;
    localparam int OVF_BITS = SAMPLE_BITS + QUO_BITS;
    localparam int CNT_BITS = $clog2(QUO_BITS);

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_COUNTED = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_READ    = 2'd2;
    localparam logic [1:0] ST_CLEARED = 2'd3;

    localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [1:0] REG_BINS       = 2'd2;
    localparam logic [1:0] REG_DROP       = 2'd3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Data handed from one divide cell to the next.
    typedef struct packed {
        logic [REM_BITS-1:0] rem;
        logic [DEN_BITS-1:0] den;
        logic [QUO_BITS-1:0] quo;
        logic                ovf;
    } t_div;

endpackage
`default_nettype wire

/* rtl/histogram_binning_counter_unit.sv */
// Top level of the histogram binning counter: control, bin store and result register.
//
// Samples are counted into bins_in_use equal-width bins between range_low and
// range_high; the bin is (sample - range_low) * bins / span truncated toward
// zero, with outliers clamped to the end bins or dropped. One item is worked
// at a time. An add runs through the multiply, the divider load, the ten
// registered cells of the divide chain (one quotient bit per cell per cycle),
// the decode, a registered read and write of the bin store and the output
// load; a dropped add ends after the decode. A read skips the multiply, the
// divide and the decode, and a clear goes straight to the output load: the
// store keeps one valid bit per bin, so a clear, like reset, empties all 256
// bins at once with no sweep. The block turns idle, open for the next item,
// on the edge that loads the result into the output register, even if it stalls.
// The user makes configuration writes only while the block is idle (not enforced).
`default_nettype none
module histogram_binning_counter_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [1:0]                      i_cfg_index,
    input  wire logic [hbc_pkg::SAMPLE_BITS-1:0] i_cfg_data,
    // input channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [1:0]                      i_opcode,
    input  wire logic signed [hbc_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic [hbc_pkg::BIN_BITS-1:0]    i_bin_select,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [1:0]                           o_status,
    output logic [hbc_pkg::BIN_BITS-1:0]         o_bin_index,
    output logic [hbc_pkg::COUNT_BITS-1:0]       o_bin_count,
    output logic [hbc_pkg::COUNT_BITS-1:0]       o_peak_count
);
    import hbc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_LOAD, S_DIV, S_DEC, S_RD, S_FIN, S_OUT
    } t_state;

    t_state r_state;

    // configuration registers
    logic signed [SAMPLE_BITS-1:0] r_range_low;
    logic signed [SAMPLE_BITS-1:0] r_range_high;
    logic [NB_BITS-1:0]            r_bins;
    logic                          r_drop;

    // item being worked
    logic                          r_is_add;
    logic signed [SAMPLE_BITS:0]   r_offset;
    logic signed [SAMPLE_BITS:0]   r_span;
    logic                          r_span_ok;
    logic                          r_neg;
    logic [REM_BITS-1:0]           r_num;
    logic [CNT_BITS-1:0]           r_cnt;
    logic [BIN_BITS-1:0]           r_addr;

    // bin store
    logic [COUNT_BITS-1:0]         r_mem [MAX_BINS];
    logic [MAX_BINS-1:0]           r_vld;
    logic [COUNT_BITS-1:0]         r_rd_data;
    logic                          r_rd_vld;
    logic                          w_wr_en;
    logic [COUNT_BITS-1:0]         r_peak;

    // staged result and output register
    logic [1:0]                    r_res_status;
    logic [BIN_BITS-1:0]           r_res_index;
    logic [COUNT_BITS-1:0]         r_res_count;
    logic [COUNT_BITS-1:0]         r_res_peak;
    logic                          r_o_valid;
    logic [1:0]                    r_o_status;
    logic [BIN_BITS-1:0]           r_o_index;
    logic [COUNT_BITS-1:0]         r_o_count;
    logic [COUNT_BITS-1:0]         r_o_peak;

    logic                          w_accept;
    logic                          w_out_free;
    logic [NB_BITS-1:0]            w_nb;
    logic [SAMPLE_BITS:0]          w_mag;
    logic [QUO_BITS-1:0]           w_quo;
    logic                          w_ovf;
    logic                          w_low;
    logic                          w_high;
    logic [BIN_BITS-1:0]           w_bin;
    logic [COUNT_BITS-1:0]         w_cur;
    logic [COUNT_BITS-1:0]         w_inc;
    logic [COUNT_BITS-1:0]         w_new_peak;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_o_valid || !i_out_stall;

    // Saturate the bin count to the supported range.
    always_comb begin
        if (r_bins < NB_BITS'(MIN_BINS)) begin
            w_nb = NB_BITS'(MIN_BINS);
        end else if (r_bins > NB_BITS'(MAX_BINS)) begin
            w_nb = NB_BITS'(MAX_BINS);
        end else begin
            w_nb = r_bins;
        end
    end

    assign w_mag = r_offset[SAMPLE_BITS] ? (-r_offset) : r_offset;

    hbc_div_chain u_div (
        .i_clk  (i_clk),
        .i_load (r_state == S_LOAD),
        .i_num  (r_num),
        .i_span (r_span[SAMPLE_BITS-1:0]),
        .o_quo  (w_quo),
        .o_ovf  (w_ovf)
    );

    // Classify the quotient. A negative offset truncates to bin 0 while the
    // quotient magnitude is zero; a non-positive span sends everything low.
    always_comb begin
        w_low  = 1'b0;
        w_high = 1'b0;
        w_bin  = w_quo[BIN_BITS-1:0];
        if (!r_span_ok) begin
            w_low = 1'b1;
        end else if (r_neg) begin
            w_low = w_ovf || (w_quo != '0);
            w_bin = '0;
        end else begin
            w_high = w_ovf || (w_quo >= QUO_BITS'(w_nb));
        end
        if (w_low) begin
            w_bin = '0;
        end else if (w_high) begin
            w_bin = BIN_BITS'(w_nb - NB_BITS'(1));
        end
    end

    // Count after the increment, holding at full scale.
    assign w_cur      = r_rd_vld ? r_rd_data : '0;
    assign w_inc      = (w_cur == COUNT_MAX) ? w_cur : (w_cur + COUNT_BITS'(1));
    assign w_new_peak = (w_inc > r_peak) ? w_inc : r_peak;
    assign w_wr_en    = (r_state == S_FIN) && r_is_add;

    // Bin store: registered read, write back of the incremented count.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_rd_data <= r_mem[r_addr];
        end
        if (w_wr_en) begin
            r_mem[r_addr] <= w_inc;
        end
    end

    // Control, configuration and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_range_low  <= '0;
            r_range_high <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            r_bins       <= NB_BITS'(MAX_BINS);
            r_drop       <= 1'b0;
            r_vld        <= '0;
            r_peak       <= '0;
            r_o_valid    <= 1'b0;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_RANGE_LOW:  r_range_low  <= i_cfg_data;
                    REG_RANGE_HIGH: r_range_high <= i_cfg_data;
                    REG_BINS:       r_bins       <= i_cfg_data[NB_BITS-1:0];
                    REG_DROP:       r_drop       <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // load a new result, or drop the old one once it is transferred
            if ((r_state == S_OUT) && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_is_add <= (i_opcode == OP_ADD);
                        r_addr   <= i_bin_select;
                        r_offset <= (SAMPLE_BITS+1)'(i_sample) -
                                    (SAMPLE_BITS+1)'(r_range_low);
                        r_span   <= (SAMPLE_BITS+1)'(r_range_high) -
                                    (SAMPLE_BITS+1)'(r_range_low);
                        case (i_opcode)
                            OP_ADD: begin
                                r_state <= S_MUL;
                            end
                            OP_CLEAR: begin
                                r_vld        <= '0;
                                r_peak       <= '0;
                                r_res_status <= ST_CLEARED;
                                r_res_index  <= '0;
                                r_res_count  <= '0;
                                r_res_peak   <= '0;
                                r_state      <= S_OUT;
                            end
                            default: begin
                                // reads, and the unused code decoded as a read
                                r_state <= S_RD;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_num     <= REM_BITS'(w_mag[SAMPLE_BITS-1:0] * w_nb);
                    r_neg     <= r_offset[SAMPLE_BITS];
                    r_span_ok <= !r_span[SAMPLE_BITS] && (r_span != '0);
                    r_state   <= S_LOAD;
                end
                S_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // advance until the last cell holds the quotient
                    if (r_cnt == CNT_BITS'(QUO_BITS - 1)) begin
                        r_state <= S_DEC;
                    end else begin
                        r_cnt <= r_cnt + CNT_BITS'(1);
                    end
                end
                S_DEC: begin
                    if ((w_low || w_high) && r_drop) begin
                        r_res_status <= ST_DROPPED;
                        r_res_index  <= '0;
                        r_res_count  <= '0;
                        r_res_peak   <= r_peak;
                        r_state      <= S_OUT;
                    end else begin
                        r_addr  <= w_bin;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_rd_vld <= r_vld[r_addr];
                    r_state  <= S_FIN;
                end
                S_FIN: begin
                    r_res_index <= r_addr;
                    if (r_is_add) begin
                        r_vld[r_addr] <= 1'b1;
                        r_peak        <= w_new_peak;
                        r_res_status  <= ST_COUNTED;
                        r_res_count   <= w_inc;
                        r_res_peak    <= w_new_peak;
                    end else begin
                        r_res_status <= ST_READ;
                        r_res_count  <= w_cur;
                        r_res_peak   <= r_peak;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register can take the result
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output payload, loaded with the valid flag.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_o_status <= r_res_status;
            r_o_index  <= r_res_index;
            r_o_count  <= r_res_count;
            r_o_peak   <= r_res_peak;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_o_valid;
    assign o_status     = r_o_status;
    assign o_bin_index  = r_o_index;
    assign o_bin_count  = r_o_count;
    assign o_peak_count = r_o_peak;

endmodule
`default_nettype wire

/* rtl/hbc_div_cell.sv */
// One restoring-divide cell: resolves one quotient bit and registers the result.
`default_nettype none
module hbc_div_cell (
    input  wire logic         i_clk,
    input  wire hbc_pkg::t_div i_d,
    output hbc_pkg::t_div     o_d
);
    import hbc_pkg::*;

    t_div r_d;
    t_div n_d;
    logic w_ge;

    always_comb begin
        w_ge      = (i_d.rem >= i_d.den);
        n_d.rem   = w_ge ? (i_d.rem - REM_BITS'(i_d.den)) : i_d.rem;
        n_d.den   = i_d.den >> 1;
        n_d.quo   = {i_d.quo[QUO_BITS-2:0], w_ge};
        n_d.ovf   = i_d.ovf;
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_d = r_d;

endmodule
`default_nettype wire

/* rtl/hbc_div_chain.sv */
// Head register and row of divide cells that turn offset times bins over span into a bin.
`default_nettype none
module hbc_div_chain (
    input  wire logic                         i_clk,
    input  wire logic                         i_load,
    input  wire logic [hbc_pkg::REM_BITS-1:0] i_num,
    input  wire logic [hbc_pkg::SAMPLE_BITS-1:0] i_span,
    output logic [hbc_pkg::QUO_BITS-1:0]      o_quo,
    output logic                              o_ovf
);
    import hbc_pkg::*;

    t_div r_head;
    t_div w_link [QUO_BITS+1];

    // Align the divisor with the top quotient bit; flag quotients too big for the row.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_head.rem <= i_num;
            r_head.den <= {i_span, {(QUO_BITS-1){1'b0}}};
            r_head.quo <= '0;
            r_head.ovf <= (OVF_BITS'(i_num) >= {i_span, {QUO_BITS{1'b0}}});
        end
    end

    assign w_link[0] = r_head;

    for (genvar g = 0; g < QUO_BITS; g++) begin : g_cell
        hbc_div_cell u_cell (
            .i_clk (i_clk),
            .i_d   (w_link[g]),
            .o_d   (w_link[g+1])
        );
    end

    assign o_quo = w_link[QUO_BITS].quo;
    assign o_ovf = w_link[QUO_BITS].ovf;

endmodule
`default_nettype wire

/* sim/histogram_binning_counter_unit_test.sv */
// Self-checking testbench of the histogram binning counter: directed and random traffic.
`timescale 1ns / 1ps
module histogram_binning_counter_unit_test;
    import hbc_pkg::*;

    // Opcode 3 has no name in the package; the block decodes it as a read.
    localparam logic [1:0] OP_SPARE = 2'd3;
    // Cycles with no transfer on either channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    // Length of the long receiver hold-off that fills the block.
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [1:0]            status;
        logic [BIN_BITS-1:0]   bin_idx;
        logic [COUNT_BITS-1:0] bin_cnt;
        logic [COUNT_BITS-1:0] peak_cnt;
    } t_hist_result;

    // Every input starts at a known value; reset is held from time zero.
    logic                   i_clk;
    logic                   i_rst_n      = 1'b0;
    logic                   i_cfg_we     = 1'b0;
    logic [1:0]             i_cfg_index  = REG_RANGE_LOW;
    logic [SAMPLE_BITS-1:0] i_cfg_data   = '0;
    logic                   i_in_valid   = 1'b0;
    logic                   o_in_stall;
    logic [1:0]             i_opcode     = OP_ADD;
    logic [SAMPLE_BITS-1:0] i_sample     = '0;
    logic [BIN_BITS-1:0]    i_bin_select = '0;
    logic                   o_out_valid;
    logic                   i_out_stall  = 1'b0;
    logic [1:0]             o_status;
    logic [BIN_BITS-1:0]    o_bin_index;
    logic [COUNT_BITS-1:0]  o_bin_count;
    logic [COUNT_BITS-1:0]  o_peak_count;

    // Shadow of the block: bin store, peak and the four registers at reset values.
    logic [COUNT_BITS-1:0]         model_counts [MAX_BINS];
    logic [COUNT_BITS-1:0]         model_peak = '0;
    logic signed [SAMPLE_BITS-1:0] model_low  = 24'sd0;
    logic signed [SAMPLE_BITS-1:0] model_high = 24'sd8388607;
    logic [8:0]                    model_bins = 9'd256;
    logic                          model_drop = 1'b0;

    t_hist_result pending_results[$];

    int fail_count    = 0;
    int idle_cycles   = 0;
    int stall_left    = 0;
    int hold_left     = 0;
    bit hold_request  = 1'b0;
    bit quiet_in      = 1'b0;
    bit quiet_out     = 1'b0;
    bit any_transfer;

    histogram_binning_counter_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_sample     (i_sample),
        .i_bin_select (i_bin_select),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_bin_index  (o_bin_index),
        .o_bin_count  (o_bin_count),
        .o_peak_count (o_peak_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        foreach (model_counts[k]) model_counts[k] = '0;
    end

    // Gap or stall length: mostly none, sometimes short, rarely a long one.
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Bin count in use after saturation to the legal range.
    function automatic longint effective_bins();
        longint nb;
        nb = longint'(model_bins);
        if (nb < MIN_BINS) nb = MIN_BINS;
        if (nb > MAX_BINS) nb = MAX_BINS;
        return nb;
    endfunction

    // Apply one item to the shadow store and return the result it must produce.
    function automatic t_hist_result tally_item(input logic [1:0] op,
                                                input logic [SAMPLE_BITS-1:0] smp,
                                                input logic [BIN_BITS-1:0] sel);
        t_hist_result res;
        longint nb, span, bin;
        res = '0;
        if (op == OP_CLEAR) begin
            foreach (model_counts[k]) model_counts[k] = '0;
            model_peak = '0;
            res.status = ST_CLEARED;
        end else if (op == OP_ADD) begin
            nb   = effective_bins();
            span = longint'(model_high) - longint'(model_low);
            // A span that is not positive counts as below the range.
            if (span <= 0) bin = -1;
            else bin = ((longint'($signed(smp)) - longint'(model_low)) * nb) / span;
            if ((bin < 0 || bin >= nb) && model_drop) begin
                res.status   = ST_DROPPED;
                res.peak_cnt = model_peak;
            end else begin
                if (bin < 0) bin = 0;
                else if (bin >= nb) bin = nb - 1;
                if (model_counts[bin] != COUNT_MAX) model_counts[bin]++;
                if (model_counts[bin] > model_peak) model_peak = model_counts[bin];
                res.status   = ST_COUNTED;
                res.bin_idx  = bin[BIN_BITS-1:0];
                res.bin_cnt  = model_counts[bin];
                res.peak_cnt = model_peak;
            end
        end else begin
            // Read, and the spare opcode decoded as one.
            res.status   = ST_READ;
            res.bin_idx  = sel;
            res.bin_cnt  = model_counts[sel];
            res.peak_cnt = model_peak;
        end
        return res;
    endfunction

    // Sample value around the configured range, with edges and full-scale noise.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        longint lo, hi, margin, v;
        lo = longint'((model_low < model_high) ? model_low : model_high);
        hi = longint'((model_low < model_high) ? model_high : model_low);
        margin = (hi - lo) / 8 + 2;
        case ($urandom_range(0, 9))
            0:       v = longint'($signed(24'($urandom)));
            1:       v = longint'(model_low);
            2:       v = longint'(model_high);
            3:       v = longint'(model_low) - 1;
            default: v = lo - margin
                         + longint'($urandom_range(0, int'(hi - lo + 2 * margin)));
        endcase
        if (v < -8388608) v = -8388608;
        if (v > 8388607) v = 8388607;
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic [BIN_BITS-1:0] pick_select();
        if ($urandom_range(0, 1)) return BIN_BITS'($urandom_range(0, int'(effective_bins() - 1)));
        return BIN_BITS'($urandom);
    endfunction

    // Offer one item, hold it until the transfer, record its result, then idle for a random gap, maybe none.
    task automatic send_item(input logic [1:0] op, input logic [SAMPLE_BITS-1:0] smp,
                             input logic [BIN_BITS-1:0] sel);
        int gap;
        t_hist_result res;
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_sample     <= smp;
        i_bin_select <= sel;
        do @(posedge i_clk); while (o_in_stall);
        res = tally_item(op, smp, sel);
        pending_results = {pending_results, res};
        gap = pick_gap(quiet_in);
        // Keep valid high when the next item follows at once.
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every result is back and the block is idle.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all four registers back to back; the unused upper data bits carry noise.
    task automatic configure(input logic signed [SAMPLE_BITS-1:0] lo,
                             input logic signed [SAMPLE_BITS-1:0] hi,
                             input logic [8:0] nbins, input logic drop);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_RANGE_LOW;
        i_cfg_data  <= lo;
        @(posedge i_clk);
        i_cfg_index <= REG_RANGE_HIGH;
        i_cfg_data  <= hi;
        @(posedge i_clk);
        i_cfg_index <= REG_BINS;
        i_cfg_data  <= {15'($urandom), nbins};
        @(posedge i_clk);
        i_cfg_index <= REG_DROP;
        i_cfg_data  <= {23'($urandom), drop};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        model_low  = lo;
        model_high = hi;
        model_bins = nbins;
        model_drop = drop;
    endtask

    task automatic compare_result();
        t_hist_result want;
        if (pending_results.size() == 0) begin
            $error("result with nothing pending: status %0d bin %0d count %0d",
                   o_status, o_bin_index, o_bin_count);
            fail_count++;
            return;
        end
        want = pending_results.pop_front();
        if (o_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, o_status);
            fail_count++;
        end
        if (o_bin_index !== want.bin_idx) begin
            $error("bin_index: expected %0d, actual %0d", want.bin_idx, o_bin_index);
            fail_count++;
        end
        if (o_bin_count !== want.bin_cnt) begin
            $error("bin_count: expected %0d, actual %0d", want.bin_cnt, o_bin_count);
            fail_count++;
        end
        if (o_peak_count !== want.peak_cnt) begin
            $error("peak_count: expected %0d, actual %0d", want.peak_cnt, o_peak_count);
            fail_count++;
        end
    endtask

    // Result side: check each transfer, count idle cycles, and drive the stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) compare_result();
        any_transfer = (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall);
        idle_cycles  = (any_transfer || !i_rst_n) ? 0 : idle_cycles + 1;
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = pick_gap(quiet_out);
        end
    end

    // Hang detection: a long stretch with no transfer ends the run.
    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("histogram_binning_counter_unit_test: FAIL");
        $finish;
    end

    // Reset values: full positive range, 256 bins, clamping.
    task automatic test_reset_state();
        send_item(OP_READ, '0, 8'd0);
        send_item(OP_ADD, 24'sd0, '0);
        send_item(OP_ADD, 24'sd8388607, '0);
        send_item(OP_ADD, -24'sd8388608, '0);
        send_item(OP_READ, '0, 8'd255);
        send_item(OP_READ, '0, 8'd0);
    endtask

    // Range edges, outliers, odd reads, clear, and degenerate settings.
    task automatic test_directed_bins();
        configure(-24'sd1000, 24'sd1000, 9'd10, 1'b1);
        send_item(OP_ADD, -24'sd1000, '0);
        // Less than one bin width below the range still lands in bin 0.
        send_item(OP_ADD, -24'sd1001, '0);
        send_item(OP_ADD, -24'sd1200, '0);
        send_item(OP_ADD, 24'sd1000, '0);
        send_item(OP_ADD, 24'sd999, '0);
        send_item(OP_ADD, 24'sd8388607, '0);
        send_item(OP_READ, '0, 8'd9);
        // Above bins in use but inside the store.
        send_item(OP_READ, '0, 8'd200);
        send_item(OP_SPARE, '0, 8'd0);
        send_item(OP_CLEAR, '1, '1);
        send_item(OP_READ, '0, 8'd0);
        // Zero span with too few bins: everything clamps to bin 0, then drops.
        configure(24'sd5, 24'sd5, 9'd2, 1'b0);
        send_item(OP_ADD, 24'sd7, '0);
        configure(24'sd5, 24'sd5, 9'd0, 1'b1);
        send_item(OP_ADD, 24'sd7, '0);
        // Full scale with too many bins.
        configure(-24'sd8388608, 24'sd8388607, 9'd511, 1'b0);
        send_item(OP_ADD, -24'sd8388608, '0);
        send_item(OP_ADD, 24'sd8388607, '0);
        send_item(OP_ADD, 24'sd0, '0);
        // Inverted range.
        configure(24'sd100, -24'sd100, 9'd3, 1'b0);
        send_item(OP_ADD, 24'sd100, '0);
        send_item(OP_READ, '0, 8'd0);
    endtask

    // Hold the result side off while items keep coming, so the input stalls.
    task automatic test_backpressure();
        configure(-24'sd4096, 24'sd4096, 9'd16, 1'b0);
        quiet_in     = 1'b1;
        hold_request = 1'b1;
        repeat (12) send_item(OP_ADD, pick_sample(), BIN_BITS'($urandom));
        send_item(OP_READ, '0, pick_select());
        quiet_in = 1'b0;
    endtask

    // Random phases: new settings each time, then a mix of adds, reads and clears.
    task automatic test_random_traffic();
        longint lo, hi;
        int mode, r;
        logic [8:0] nbins;
        for (int phase = 0; phase < 10; phase++) begin
            lo = longint'($urandom_range(0, 16777215)) - 8388608;
            mode = $urandom_range(0, 7);
            case (mode)
                0: begin
                    lo = -8388608;
                    hi = 8388607;
                end
                1:       hi = lo + $urandom_range(3, 5000);
                2:       hi = longint'($urandom_range(0, 16777215)) - 8388608;
                3:       hi = lo;
                default: hi = lo + $urandom_range(5000, 2000000);
            endcase
            if (hi > 8388607) hi = 8388607;
            r = $urandom_range(0, 9);
            if (r < 6) nbins = 9'($urandom_range(3, 16));
            else if (r < 8) nbins = 9'($urandom_range(17, 256));
            else if (r == 8) nbins = 9'($urandom_range(0, 2));
            else nbins = 9'($urandom_range(257, 511));
            configure(lo[SAMPLE_BITS-1:0], hi[SAMPLE_BITS-1:0], nbins, 1'($urandom));
            // Some phases run back to back on one side or both.
            quiet_in  = ($urandom_range(0, 3) == 0);
            quiet_out = ($urandom_range(0, 3) == 0);
            repeat (160) begin
                r = $urandom_range(0, 99);
                if (r < 74) send_item(OP_ADD, pick_sample(), BIN_BITS'($urandom));
                else if (r < 92) send_item(OP_READ, 24'($urandom), pick_select());
                else if (r < 97) send_item(OP_SPARE, 24'($urandom), pick_select());
                else send_item(OP_CLEAR, 24'($urandom), BIN_BITS'($urandom));
            end
        end
        quiet_in  = 1'b0;
        quiet_out = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_directed_bins();
        test_backpressure();
        test_random_traffic();
        // Drain, then give stray results time to show up.
        settle();
        repeat (40) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("histogram_binning_counter_unit_test: PASS");
        end else begin
            $display("histogram_binning_counter_unit_test: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/hbc_pkg.sv
rtl/hbc_div_cell.sv
rtl/hbc_div_chain.sv
rtl/histogram_binning_counter_unit.sv
sim/histogram_binning_counter_unit_test.sv
